[hdl/akd_pkg.sv]
// Shared types and constants for the ANSI key sequence decoder.
package akd_pkg;

	// Parameter bytes counted per CSI sequence (default); only the first is stored
	localparam int PARAM_DEPTH_DEF = 8;
	// Entries in the queue between parser and output stage (default)
	localparam int QUEUE_DEPTH_DEF = 4;

	// Key codes
	localparam logic [7:0] KEY_BS    = 8'h08;
	localparam logic [7:0] KEY_LF    = 8'h0A;
	localparam logic [7:0] KEY_CR    = 8'h0D;
	localparam logic [7:0] KEY_ESC   = 8'h1B;
	localparam logic [7:0] KEY_DEL   = 8'h7F;
	localparam logic [7:0] KEY_LBRK  = 8'h5B;
	localparam logic [7:0] KEY_A     = 8'h41;
	localparam logic [7:0] KEY_B     = 8'h42;
	localparam logic [7:0] KEY_C     = 8'h43;
	localparam logic [7:0] KEY_D     = 8'h44;
	localparam logic [7:0] KEY_TILDE = 8'h7E;
	localparam logic [7:0] KEY_ZERO  = 8'h30;
	localparam logic [7:0] KEY_THREE = KEY_ZERO + 8'd3;
	// CSI final byte range
	localparam logic [7:0] FINAL_LO  = 8'h40;
	localparam logic [7:0] FINAL_HI  = 8'h7E;

	// Input opcodes
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_IDLE = 1'b1;

	typedef enum logic [1:0] {
		MODE_PLAIN = 2'd0,
		MODE_ESC   = 2'd1,
		MODE_CSI   = 2'd2
	} mode_t;

	typedef enum logic [3:0] {
		ACT_BACKSPACE = 4'd0,
		ACT_ENTER     = 4'd1,
		ACT_BACK      = 4'd2,
		ACT_UP        = 4'd3,
		ACT_DOWN      = 4'd4,
		ACT_RIGHT     = 4'd5,
		ACT_LEFT      = 4'd6,
		ACT_CLEAR     = 4'd7,
		ACT_CHAR      = 4'd8
	} action_t;

	// One result transaction
	typedef struct packed {
		action_t    action;
		logic [7:0] char_code;
	} result_t;

endpackage

[hdl/akd_front.sv]
// Front end: accepts key transactions, tracks the escape parser state, emits results.
module akd_front import akd_pkg::*; #(
	parameter int PARAM_DEPTH = PARAM_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic       q_full,
	input  logic       opcode,
	input  logic [7:0] byte_value,
	output logic       wr_en,
	output result_t    wr_data
);

	localparam int CntW = $clog2(PARAM_DEPTH + 1);
	localparam logic [CntW-1:0] CntMax = CntW'(PARAM_DEPTH);

	mode_t           mode_q, mode_d;
	logic [7:0]      last_q, last_d;
	logic [7:0]      first_param_q;
	logic            first_we;
	logic [CntW-1:0] count_q, count_d;
	logic            accept;
	logic            is_final;
	logic            emit;
	action_t         act;
	logic [7:0]      ch;

	assign accept   = push && !q_full;
	assign is_final = (byte_value >= FINAL_LO) && (byte_value <= FINAL_HI);

	// Next parser state
	always_comb begin
		mode_d   = mode_q;
		last_d   = last_q;
		count_d  = count_q;
		first_we = 1'b0;
		if (opcode == OP_BYTE) begin
			unique case (mode_q)
				MODE_PLAIN: begin
					last_d = byte_value;
					if (byte_value == KEY_ESC) begin
						mode_d = MODE_ESC;
					end
				end
				MODE_ESC: begin
					if (byte_value == KEY_LBRK) begin
						mode_d = MODE_CSI;
					end else begin
						mode_d  = MODE_PLAIN;
						count_d = '0;
					end
				end
				MODE_CSI: begin
					if (is_final) begin
						mode_d  = MODE_PLAIN;
						count_d = '0;
					end else if (count_q < CntMax) begin
						first_we = (count_q == '0);
						count_d  = count_q + CntW'(1);
					end
				end
				default: begin
					mode_d  = MODE_PLAIN;
					count_d = '0;
				end
			endcase
		end
	end

	// Result decode
	always_comb begin
		emit = 1'b0;
		act  = ACT_CHAR;
		ch   = 8'h00;
		if (opcode == OP_IDLE) begin
			priority if (last_q == KEY_CR) begin
				emit = 1'b1;
				act  = ACT_ENTER;
			end else if (last_q == KEY_ESC) begin
				emit = 1'b1;
				act  = ACT_BACK;
			end else begin
				emit = 1'b0;
			end
		end else begin
			unique case (mode_q)
				MODE_PLAIN: begin
					priority if (byte_value == KEY_BS || byte_value == KEY_DEL) begin
						emit = 1'b1;
						act  = ACT_BACKSPACE;
					end else if (byte_value == KEY_LF) begin
						emit = 1'b1;
						act  = ACT_ENTER;
					end else if (byte_value == KEY_CR || byte_value == KEY_ESC) begin
						emit = 1'b0;
					end else begin
						emit = 1'b1;
						act  = ACT_CHAR;
						ch   = byte_value;
					end
				end
				MODE_CSI: begin
					if (is_final) begin
						priority if (byte_value == KEY_A) begin
							emit = 1'b1;
							act  = ACT_UP;
						end else if (byte_value == KEY_B) begin
							emit = 1'b1;
							act  = ACT_DOWN;
						end else if (byte_value == KEY_C) begin
							emit = 1'b1;
							act  = ACT_RIGHT;
						end else if (byte_value == KEY_D) begin
							emit = 1'b1;
							act  = ACT_LEFT;
						end else if (byte_value == KEY_TILDE && count_q != '0
							&& first_param_q == KEY_THREE) begin
							emit = 1'b1;
							act  = ACT_CLEAR;
						end else begin
							emit = 1'b0;
						end
					end
				end
				default: begin
					emit = 1'b0;
				end
			endcase
		end
	end

	assign wr_en             = accept && emit;
	assign wr_data.action    = act;
	assign wr_data.char_code = ch;

	// Parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_PLAIN;
			last_q  <= 8'h00;
			count_q <= '0;
		end else if (accept) begin
			mode_q  <= mode_d;
			last_q  <= last_d;
			count_q <= count_d;
		end
	end

	// First CSI parameter byte, only read once count is nonzero
	always_ff @(posedge clk) begin
		if (accept && first_we) begin
			first_param_q <= byte_value;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntMax)
		else $error("parameter count beyond depth");

	a_idle_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && opcode == OP_IDLE) |=> ($stable(mode_q) && $stable(last_q)
			&& $stable(count_q)))
		else $error("idle transaction changed parser state");

	a_count_only_csi: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_PLAIN) |-> (count_q == '0))
		else $error("parameter count left over in plain mode");

endmodule

[hdl/akd_queue.sv]
// Small result queue decoupling the parser from the output stage.
module akd_queue import akd_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    wr_en,
	input  result_t wr_data,
	output logic    full,
	input  logic    rd_en,
	output logic    rd_valid,
	output result_t rd_data
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

	result_t         mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_rd;

	assign full     = (count_q == CntFull);
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_rd    = rd_en && rd_valid;

	// Storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
			end
			priority if (wr_en && !do_rd) begin
				count_q <= count_q + CntW'(1);
			end else if (do_rd && !wr_en) begin
				count_q <= count_q - CntW'(1);
			end else begin
				count_q <= count_q;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && full))
		else $error("write into full queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntFull)
		else $error("queue count beyond depth");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && !do_rd) |=> (count_q == $past(count_q) + CntW'(1)))
		else $error("queue count missed a write");

endmodule

[hdl/akd_back.sv]
// Back end: output register that presents one result transaction at a time.
module akd_back import akd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  result_t    q_data,
	output logic       q_rd,
	output logic       empty,
	input  logic       pop,
	output logic [3:0] action,
	output logic [7:0] char_code
);

	logic    valid_q;
	result_t res_q;
	logic    load;

	// Refill when the register is free or being drained this cycle
	assign load = q_valid && (!valid_q || pop);
	assign q_rd = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= q_data;
		end
	end

	assign empty     = !valid_q;
	assign action    = res_q.action;
	assign char_code = res_q.char_code;

	a_drain_refill: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && pop && q_valid) |=> valid_q)
		else $error("output register dropped a waiting result");

	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !pop) |-> !q_rd)
		else $error("queue read while output stalled");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(!valid_q && !q_valid) |=> !valid_q)
		else $error("result appeared with nothing queued");

endmodule

[hdl/ansi_key_sequence_decoder_top.sv]
// Top level of the ANSI key sequence decoder.
//
// Input channel: an opcode (received byte or idle timeout) and byte_value are
// taken as a transaction when push is high and full is low. Result channel:
// while empty is low, action and char_code hold the oldest result; it is
// taken when pop is high. Each input transaction gives zero or one result.
//
// Throughput: one input transaction per cycle while full is low. The parser updates its mode
// state in the same cycle it accepts a byte, so bytes follow back to back.
// The accepting edge writes a result into the queue; it shows on the output once it is
// loaded into the output register, which takes it when that register is free or being popped.
//
// A stalled receiver fills the output register and then the queue
// (QUEUE_DEPTH entries); full rises only when the queue has no free slot.
// Inputs that give no result never occupy a slot.
//
// Reset (arst_n low) empties the queue and output register and returns the
// parser to plain mode with no last byte and no collected parameters.
module ansi_key_sequence_decoder_top import akd_pkg::*; #(
	parameter int PARAM_DEPTH = PARAM_DEPTH_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic       opcode,
	input  logic [7:0] byte_value,
	output logic       empty,
	input  logic       pop,
	output logic [3:0] action,
	output logic [7:0] char_code
);

	logic    wr_en;
	result_t wr_data;
	logic    q_valid;
	logic    q_rd;
	result_t q_data;

	akd_front #(
		.PARAM_DEPTH(PARAM_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.q_full    (full),
		.opcode    (opcode),
		.byte_value(byte_value),
		.wr_en     (wr_en),
		.wr_data   (wr_data)
	);

	akd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_data (wr_data),
		.full    (full),
		.rd_en   (q_rd),
		.rd_valid(q_valid),
		.rd_data (q_data)
	);

	akd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_data   (q_data),
		.q_rd     (q_rd),
		.empty    (empty),
		.pop      (pop),
		.action   (action),
		.char_code(char_code)
	);

endmodule

[tb/sv/ansi_key_sequence_decoder_top_tb.sv]
// Self-checking testbench for the ANSI key sequence decoder: directed and random key streams.
module ansi_key_sequence_decoder_top_tb import akd_pkg::*; ();

	localparam int DEPTH     = PARAM_DEPTH_DEF;
	localparam int ITEMS     = 1800;
	localparam int LONG_HOLD = 300;
	localparam int DRAIN     = 8;
	localparam int LIMIT     = 200000;

	// Predicts decoder actions from accepted transactions and checks results in order
	class key_action_scoreboard;
		mode_t       mode;
		logic [7:0]  last_plain;
		logic [7:0]  first_param;
		logic [3:0]  param_cnt;
		result_t     pending[$];
		int          n_errors;
		int          n_checked;
		int          n_inputs;
		int          n_idle;
		int          act_count[9];

		function new();
			mode        = MODE_PLAIN;
			last_plain  = 8'h00;
			first_param = 8'h00;
			param_cnt   = 4'd0;
			n_errors    = 0;
			n_checked   = 0;
			n_inputs    = 0;
			n_idle      = 0;
			foreach (act_count[i]) act_count[i] = 0;
		endfunction

		function void note_input(logic op, logic [7:0] b);
			result_t r;
			bit      hit;
			hit = 1'b0;
			r.char_code = 8'h00;
			r.action = ACT_CHAR;
			n_inputs++;
			if (op == OP_IDLE) begin
				// idle only looks at the last plain byte, state is untouched
				n_idle++;
				if (last_plain == KEY_CR) begin
					r.action = ACT_ENTER;
					hit = 1'b1;
				end else if (last_plain == KEY_ESC) begin
					r.action = ACT_BACK;
					hit = 1'b1;
				end
			end else begin
				case (mode)
					MODE_PLAIN: begin
						if (b == KEY_BS || b == KEY_DEL) begin
							r.action = ACT_BACKSPACE;
							hit = 1'b1;
						end else if (b == KEY_LF) begin
							r.action = ACT_ENTER;
							hit = 1'b1;
						end else if (b == KEY_ESC) begin
							mode = MODE_ESC;
						end else if (b != KEY_CR) begin
							r.action = ACT_CHAR;
							r.char_code = b;
							hit = 1'b1;
						end
						last_plain = b;
					end
					MODE_ESC: begin
						if (b == KEY_LBRK) begin
							mode = MODE_CSI;
						end else begin
							mode = MODE_PLAIN;
							param_cnt = 4'd0;
						end
					end
					MODE_CSI: begin
						if (b >= FINAL_LO && b <= FINAL_HI) begin
							hit = 1'b1;
							case (b)
								KEY_A: r.action = ACT_UP;
								KEY_B: r.action = ACT_DOWN;
								KEY_C: r.action = ACT_RIGHT;
								KEY_D: r.action = ACT_LEFT;
								KEY_TILDE: begin
									if (param_cnt != 4'd0 && first_param == KEY_THREE)
										r.action = ACT_CLEAR;
									else
										hit = 1'b0;
								end
								default: hit = 1'b0;
							endcase
							mode = MODE_PLAIN;
							param_cnt = 4'd0;
						end else if (param_cnt < DEPTH) begin
							// parameter byte; excess ones are dropped
							if (param_cnt == 4'd0)
								first_param = b;
							param_cnt = param_cnt + 4'd1;
						end
					end
					default: begin
						mode = MODE_PLAIN;
						param_cnt = 4'd0;
					end
				endcase
			end
			if (hit)
				pending.push_back(r);
		endfunction

		function void check_result(logic [3:0] act, logic [7:0] ch);
			result_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result: action %0d char_code 0x%02h",
					$time, act, ch);
				n_errors++;
				return;
			end
			want = pending.pop_front();
			n_checked++;
			if (want.action <= ACT_CHAR)
				act_count[want.action]++;
			if (act !== want.action) begin
				$display("%0t: action mismatch: expected %0d actual %0d",
					$time, want.action, act);
				n_errors++;
			end
			if (ch !== want.char_code) begin
				$display("%0t: char_code mismatch: expected 0x%02h actual 0x%02h",
					$time, want.char_code, ch);
				n_errors++;
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic       opcode = OP_BYTE;
	logic [7:0] byte_value = 8'h00;
	logic       empty;
	logic       pop = 1'b0;
	logic [3:0] action;
	logic [7:0] char_code;

	key_action_scoreboard sb = new();

	int n_sent = 0;
	int n_full_waits = 0;
	int n_cycles = 0;
	int send_quiet = 0;
	int recv_quiet = 0;
	int n_holds = 0;

	ansi_key_sequence_decoder_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.opcode     (opcode),
		.byte_value (byte_value),
		.empty      (empty),
		.pop        (pop),
		.action     (action),
		.char_code  (char_code)
	);

	// Clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Timeout guard
	always @(posedge clk) begin
		n_cycles <= n_cycles + 1;
		if (n_cycles == LIMIT) begin
			$display("timeout after %0d cycles", n_cycles);
			$display("** ansi_key_sequence_decoder_top: FAILED **");
			$finish;
		end
	end

	// Wait between transactions, drawn at random, with runs of back-to-back traffic
	function automatic int draw_gap(inout int quiet);
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			quiet = $urandom_range(20, 60);
			return 0;
		end
		return $urandom_range(0, 16);
	endfunction

	// One input transaction; push stays high afterward so items can follow back to back
	task automatic send_item(input logic op, input logic [7:0] b);
		int gap;
		gap = draw_gap(send_quiet);
		@(negedge clk);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		opcode <= op;
		byte_value <= b;
		do begin
			@(posedge clk);
			if (full)
				n_full_waits++;
		end while (full);
		sb.note_input(op, b);
		n_sent++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_item(OP_BYTE, b);
	endtask

	// byte_value is don't-care for idle, so keep it toggling
	task automatic send_idle();
		send_item(OP_IDLE, 8'($urandom));
	endtask

	function automatic logic [7:0] param_byte(bit first);
		int sel;
		sel = $urandom_range(0, 9);
		if (first && sel < 4)
			return KEY_THREE;
		if (sel < 7)
			return KEY_ZERO + 8'($urandom_range(0, 9));
		if (sel == 7)
			return 8'h3B;
		if ($urandom_range(0, 1))
			return 8'($urandom_range(8'h00, 8'h3F));
		return 8'($urandom_range(8'h7F, 8'hFF));
	endfunction

	function automatic logic [7:0] final_byte();
		case ($urandom_range(0, 9))
			0, 1: return KEY_A;
			2: return KEY_B;
			3: return KEY_C;
			4: return KEY_D;
			5, 6: return KEY_TILDE;
			default: return 8'($urandom_range(FINAL_LO, FINAL_HI));
		endcase
	endfunction

	function automatic logic [7:0] plain_byte();
		case ($urandom_range(0, 9))
			0: return KEY_BS;
			1: return KEY_DEL;
			2: return KEY_LF;
			3: return KEY_CR;
			4: return KEY_ESC;
			default: return 8'($urandom);
		endcase
	endfunction

	// Edge cases: every plain control key, idle after CR/ESC/other, final keys A and tilde
	task automatic run_directed();
		send_byte(KEY_BS);
		send_byte(KEY_DEL);
		send_byte(KEY_LF);
		send_byte(KEY_CR);
		send_idle();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_idle();
		send_byte(KEY_ESC);
		send_idle();
		// unsupported escape byte
		send_byte(8'h78);
		send_byte(KEY_ESC);
		send_byte(KEY_LBRK);
		send_byte(KEY_A);
		send_byte(KEY_ESC);
		send_byte(KEY_LBRK);
		send_byte(KEY_THREE);
		send_byte(KEY_TILDE);
		// tilde with no parameter, then with the wrong one
		send_byte(KEY_ESC);
		send_byte(KEY_LBRK);
		send_byte(KEY_TILDE);
		send_byte(KEY_ESC);
		send_byte(KEY_LBRK);
		send_byte(KEY_ZERO + 8'd2);
		send_byte(KEY_TILDE);
	endtask

	// Mostly well-formed CSI sequences and plain keys, plus broken sequences and noise
	task automatic run_random();
		int kind;
		int n_param;
		while (n_sent < ITEMS) begin
			kind = $urandom_range(0, 99);
			if (kind < 45) begin
				send_byte(KEY_ESC);
				send_byte(KEY_LBRK);
				if ($urandom_range(0, 9) < 7)
					n_param = $urandom_range(0, 3);
				else
					n_param = $urandom_range(4, DEPTH + 4);
				for (int i = 0; i < n_param; i++) begin
					send_byte(param_byte(i == 0));
					if ($urandom_range(0, 49) == 0)
						send_idle();
				end
				// occasionally leave the sequence unterminated
				if ($urandom_range(0, 19) != 0)
					send_byte(final_byte());
			end else if (kind < 70) begin
				send_byte(plain_byte());
			end else if (kind < 80) begin
				send_byte(KEY_ESC);
				if ($urandom_range(0, 3) == 0)
					send_idle();
				send_byte(8'($urandom));
			end else if (kind < 90) begin
				send_idle();
			end else begin
				send_item(1'($urandom), 8'($urandom));
			end
		end
	endtask

	// Result side: random pops, plus two long hold-offs to back up the queue
	initial begin
		int gap;
		wait (arst_n === 1'b1);
		forever begin
			if ((n_holds == 0 && sb.n_checked >= 100) ||
				(n_holds == 1 && sb.n_checked >= 700)) begin
				gap = LONG_HOLD;
				n_holds++;
			end else begin
				gap = draw_gap(recv_quiet);
			end
			@(negedge clk);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			sb.check_result(action, char_code);
		end
	end

	// Reset, stimulus, drain and verdict
	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		run_directed();
		run_random();
		@(negedge clk);
		push <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		$display("Run covered %0d transactions (%0d idle), %0d results checked",
			sb.n_inputs, sb.n_idle, sb.n_checked);
		$display("Input stalls %0d; by action: bksp %0d enter %0d back %0d up %0d",
			n_full_waits, sb.act_count[0], sb.act_count[1], sb.act_count[2],
			sb.act_count[3]);
		$display("  down %0d right %0d left %0d clear %0d char %0d",
			sb.act_count[4], sb.act_count[5], sb.act_count[6], sb.act_count[7],
			sb.act_count[8]);
		if (sb.n_errors == 0) begin
			$display("** ansi_key_sequence_decoder_top: PASSED **");
		end else begin
			$display("** ansi_key_sequence_decoder_top: FAILED **");
		end
		$finish;
	end

endmodule
